// ----- hdl/bse_pkg.sv -----
package bse_pkg;

  // Patch geometry and store
  localparam int MAX_DEGREE = 4;
  localparam int DIM        = MAX_DEGREE + 1;
  localparam int GRID_N     = DIM * DIM;
  localparam int ADDR_W     = $clog2(GRID_N);
  localparam int IDX_W      = 3;
  localparam int DEG_W      = 3;

  // Number formats
  localparam int COORD_W   = 32;
  localparam int DERIV_W   = COORD_W + 8;
  localparam int FRAC_BITS = 16;
  localparam int PARAM_W   = FRAC_BITS + 1;
  localparam int PT_W      = 3 * COORD_W;

  // Shared multiplier: unsigned weight times signed value
  localparam int WGT_W  = FRAC_BITS + 3;
  localparam int DIFF_W = COORD_W + 1;
  localparam int MB_W   = DIFF_W + 1;
  localparam int MA_W   = WGT_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int RND_W  = PROD_W - FRAC_BITS;
  localparam int ACC_W  = COORD_W + 24;

  // Configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [PARAM_W-1:0] ONE_Q = PARAM_W'(1) << FRAC_BITS;

  // Request codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Register indexes
  localparam logic REG_U_DEGREE = 1'b0;
  localparam logic REG_V_DEGREE = 1'b1;

  // Control point store write port
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [PT_W-1:0]   data;
  } bse_wr_t;

  // Binomial coefficient C(n,i) for n up to four
  function automatic logic [2:0] binom(input logic [2:0] n, input logic [2:0] i);
    logic [2:0] c;
    case ({n, i}) inside
      6'o00, 6'o10, 6'o11, 6'o20, 6'o22,
      6'o30, 6'o33, 6'o40, 6'o44:          c = 3'd1;
      6'o21:                               c = 3'd2;
      6'o31, 6'o32:                        c = 3'd3;
      6'o41, 6'o43:                        c = 3'd4;
      6'o42:                               c = 3'd6;
      default:                             c = 3'd0;
    endcase
    return c;
  endfunction

  // Row-major store address, row along v, column along u
  function automatic logic [ADDR_W-1:0] grid_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(DIM) + ADDR_W'(col);
  endfunction

endpackage

// ----- hdl/bse_in_if.sv -----
interface bse_in_if import bse_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      cmd;
  logic [IDX_W-1:0]          u_index;
  logic [IDX_W-1:0]          v_index;
  logic signed [COORD_W-1:0] ctrl_x;
  logic signed [COORD_W-1:0] ctrl_y;
  logic signed [COORD_W-1:0] ctrl_z;
  logic [PARAM_W-1:0]        param_u;
  logic [PARAM_W-1:0]        param_v;

  modport source (output valid, cmd, u_index, v_index, ctrl_x, ctrl_y, ctrl_z,
                  param_u, param_v, input ready);
  modport sink   (input valid, cmd, u_index, v_index, ctrl_x, ctrl_y, ctrl_z,
                  param_u, param_v, output ready);
endinterface

// ----- hdl/bse_out_if.sv -----
interface bse_out_if import bse_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic signed [DERIV_W-1:0] du_x;
  logic signed [DERIV_W-1:0] du_y;
  logic signed [DERIV_W-1:0] du_z;
  logic signed [DERIV_W-1:0] dv_x;
  logic signed [DERIV_W-1:0] dv_y;
  logic signed [DERIV_W-1:0] dv_z;
  logic                      status;

  modport source (output valid, pos_x, pos_y, pos_z, du_x, du_y, du_z,
                  dv_x, dv_y, dv_z, status, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, du_x, du_y, du_z,
                  dv_x, dv_y, dv_z, status, output ready);
endinterface

// ----- hdl/bse_mul.sv -----
module bse_mul import bse_pkg::*; (
  input  logic                     clk,
  input  logic [WGT_W-1:0]         op_a,
  input  logic signed [MB_W-1:0]   op_b,
  output logic signed [RND_W-1:0]  rnd
);

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] sum;

  // Registered product
  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, op_a}) * op_b;
  end

  // Round half up back to the fraction format
  assign sum = prod_r + HALF;
  assign rnd = sum[PROD_W-1:FRAC_BITS];

endmodule

// ----- hdl/bse_store.sv -----
module bse_store import bse_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  bse_wr_t           wr,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [PT_W-1:0]   rd_data
);

  logic [PT_W-1:0]   mem_r [GRID_N];
  logic [GRID_N-1:0] vld_r;
  logic [PT_W-1:0]   q_r;
  logic              hit_r;

  // Point memory, registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    q_r <= mem_r[rd_addr];
  end

  // Per-entry valid bits; an unwritten entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.addr] <= 1'b1;
    end
    hit_r <= (rd_addr < ADDR_W'(GRID_N)) && vld_r[rd_addr];
  end

  assign rd_data = hit_r ? q_r : '0;

endmodule

// ----- hdl/bezier_surface_evaluator_top.sv -----
// Bezier surface evaluator, degree 2 to 4 along u and v.
// Input channel in_if: a write request (cmd 0) stores one control point at
// column u_index, row v_index; an index above the degree answers status 1.
// An evaluate request (cmd 1) returns the surface point at param_u, param_v
// together with both partial derivatives. Every request gives one result on
// out_if. Degrees are set over the cfg_ APB port; a legal degree write
// clears the whole control grid.
// An evaluation first builds the four Bernstein weight tables, bu, du,
// bv and dv, one factor at a time on the shared multiplier, then walks
// the control grid point by point, weighting each point and the
// differences to its right and lower neighbors on the same multiplier.
// One request is worked on at a time; in_if.ready is high
// only while idle. The result sits in an output register; if the receiver
// stalls, a finished request waits there and the next request may still
// be accepted and computed, holding its result until the register frees.
// Reset sets both degrees to 3, clears the grid and drops out_if.valid.
module bezier_surface_evaluator_top import bse_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bse_in_if.sink                in_if,
  bse_out_if.source             out_if,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int DP_W = ACC_W + DEG_W + 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_BMUL = 5'b00010,
    ST_BRND = 5'b00100,
    ST_GRID = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t                    state_r;
  logic [DEG_W-1:0]          nu_r, nv_r;
  logic [PARAM_W-1:0]        tu_r, tv_r;
  logic [1:0]                tsel_r;
  logic [IDX_W-1:0]          idx_r, k_r;
  logic [WGT_W-1:0]          wacc_r;
  logic [WGT_W-1:0]          wt_r [4][DIM];
  logic [IDX_W-1:0]          gi_r, gj_r;
  logic [3:0]                gstep_r;
  logic [WGT_W-1:0]          w_r, wu_r, wv_r;
  logic signed [COORD_W-1:0] p_r  [3];
  logic signed [DIFF_W-1:0]  dr_r [3];
  logic signed [DIFF_W-1:0]  dd_r [3];
  logic signed [ACC_W-1:0]   pos_acc_r [3];
  logic signed [ACC_W-1:0]   gu_acc_r  [3];
  logic signed [ACC_W-1:0]   gv_acc_r  [3];
  logic                      status_r;
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] pos_out_r [3];
  logic signed [DERIV_W-1:0] du_out_r  [3];
  logic signed [DERIV_W-1:0] dv_out_r  [3];
  logic                      status_out_r;

  logic                      cfg_wr, cfg_clr;
  logic [DEG_W-1:0]          cfg_val;
  logic                      in_acc;
  logic                      idx_ok;
  logic [DEG_W-1:0]          tab_n;
  logic [PARAM_W-1:0]        t_cur, s_cur, factor;
  logic [WGT_W-1:0]          op_a;
  logic signed [MB_W-1:0]    op_b;
  logic signed [RND_W-1:0]   mul_rnd;
  logic [WGT_W-1:0]          rnd_w;
  logic signed [ACC_W-1:0]   rnd_acc;
  logic [WGT_W-1:0]          bu_j, du_j, bv_i, dv_i;
  bse_wr_t                   st_wr;
  logic [ADDR_W-1:0]         rd_addr;
  logic [PT_W-1:0]           rd_data;
  logic signed [COORD_W-1:0] rd_c [3];
  logic signed [DP_W-1:0]    gu_sc [3];
  logic signed [DP_W-1:0]    gv_sc [3];
  logic                      out_load;

  // Degree of Bernstein table: bu, du, bv, dv
  function automatic logic [DEG_W-1:0] deg_of(input logic [1:0] sel,
                                              input logic [DEG_W-1:0] nu,
                                              input logic [DEG_W-1:0] nv);
    logic [DEG_W-1:0] d;
    case (sel)
      2'd0:    d = nu;
      2'd1:    d = nu - DEG_W'(1);
      2'd2:    d = nv;
      default: d = nv - DEG_W'(1);
    endcase
    return d;
  endfunction

  function automatic logic [WGT_W-1:0] wgt_init(input logic [2:0] n, input logic [2:0] i);
    return {binom(n, i), {FRAC_BITS{1'b0}}};
  endfunction

  function automatic logic signed [MB_W-1:0] wext(input logic [WGT_W-1:0] w);
    return $signed({{(MB_W - WGT_W){1'b0}}, w});
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_pos(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-COORD_W:0] top;
    top = x[ACC_W-1:COORD_W-1];
    if (&top || ~|top) return x[COORD_W-1:0];
    return x[ACC_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
  endfunction

  function automatic logic signed [DERIV_W-1:0] sat_der(input logic signed [DP_W-1:0] x);
    logic [DP_W-DERIV_W:0] top;
    top = x[DP_W-1:DERIV_W-1];
    if (&top || ~|top) return x[DERIV_W-1:0];
    return x[DP_W-1] ? {1'b1, {(DERIV_W-1){1'b0}}} : {1'b0, {(DERIV_W-1){1'b1}}};
  endfunction

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_val    = cfg_pwdata[DEG_W-1:0];
  assign cfg_clr    = cfg_wr && (cfg_val >= DEG_W'(2)) && (cfg_val <= DEG_W'(MAX_DEGREE));
  assign cfg_prdata = {{(CFG_DATA_W - DEG_W){1'b0}},
                       (cfg_paddr[2] == REG_V_DEGREE) ? nv_r : nu_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nu_r <= DEG_W'(3);
      nv_r <= DEG_W'(3);
    end else if (cfg_clr) begin
      if (cfg_paddr[2] == REG_U_DEGREE) begin
        nu_r <= cfg_val;
      end else begin
        nv_r <= cfg_val;
      end
    end
  end

  // Request intake
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign idx_ok      = (in_if.u_index <= nu_r) && (in_if.v_index <= nv_r);

  assign st_wr.en   = in_acc && (in_if.cmd == CMD_WRITE) && idx_ok;
  assign st_wr.addr = grid_addr(in_if.v_index, in_if.u_index);
  assign st_wr.data = {in_if.ctrl_z, in_if.ctrl_y, in_if.ctrl_x};

  // Bernstein factor selection: s for the first n-i steps, then t
  assign tab_n  = deg_of(tsel_r, nu_r, nv_r);
  assign t_cur  = tsel_r[1] ? tv_r : tu_r;
  assign s_cur  = ONE_Q - t_cur;
  assign factor = ((IDX_W + 1)'(k_r) + (IDX_W + 1)'(idx_r) < (IDX_W + 1)'(tab_n)) ?
                  s_cur : t_cur;

  assign bu_j = wt_r[0][gj_r];
  assign du_j = wt_r[1][gj_r];
  assign bv_i = wt_r[2][gi_r];
  assign dv_i = wt_r[3][gi_r];

  // Multiplier operand schedule
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == ST_BMUL) begin
      op_a = wacc_r;
      op_b = wext(WGT_W'(factor));
    end else if (state_r == ST_GRID) begin
      case (gstep_r)
        4'd0: begin
          op_a = bu_j;
          op_b = wext(bv_i);
        end
        4'd1: begin
          op_a = (gj_r == nu_r) ? '0 : du_j;
          op_b = wext(bv_i);
        end
        4'd2: begin
          op_a = (gi_r == nv_r) ? '0 : dv_i;
          op_b = wext(bu_j);
        end
        4'd3, 4'd4, 4'd5: begin
          op_a = w_r;
          op_b = MB_W'(p_r[2'(gstep_r - 4'd3)]);
        end
        4'd6, 4'd7, 4'd8: begin
          op_a = wu_r;
          op_b = MB_W'(dr_r[2'(gstep_r - 4'd6)]);
        end
        4'd9, 4'd10, 4'd11: begin
          op_a = wv_r;
          op_b = MB_W'(dd_r[2'(gstep_r - 4'd9)]);
        end
        default: begin
          op_a = '0;
          op_b = '0;
        end
      endcase
    end
  end

  bse_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .rnd  (mul_rnd)
  );

  assign rnd_w   = mul_rnd[WGT_W-1:0];
  assign rnd_acc = ACC_W'(mul_rnd);

  // Store read: point, right neighbor, lower neighbor
  always_comb begin
    case (gstep_r)
      4'd0:    rd_addr = grid_addr(gi_r, gj_r);
      4'd1:    rd_addr = grid_addr(gi_r, gj_r + IDX_W'(1));
      default: rd_addr = grid_addr(gi_r + IDX_W'(1), gj_r);
    endcase
  end

  bse_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cfg_clr),
    .wr      (st_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_c[0] = rd_data[COORD_W-1:0];
  assign rd_c[1] = rd_data[2*COORD_W-1:COORD_W];
  assign rd_c[2] = rd_data[3*COORD_W-1:2*COORD_W];

  // Final scaling of derivatives by degree
  for (genvar c = 0; c < 3; c++) begin : g_scale
    assign gu_sc[c] = gu_acc_r[c] * $signed({1'b0, nu_r});
    assign gv_sc[c] = gv_acc_r[c] * $signed({1'b0, nv_r});
  end

  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_if.ready);

  // Sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            for (int c = 0; c < 3; c++) begin
              pos_acc_r[c] <= '0;
              gu_acc_r[c]  <= '0;
              gv_acc_r[c]  <= '0;
            end
            if (in_if.cmd == CMD_WRITE) begin
              status_r <= !idx_ok;
              state_r  <= ST_FIN;
            end else begin
              status_r <= 1'b0;
              tu_r     <= (in_if.param_u > ONE_Q) ? ONE_Q : in_if.param_u;
              tv_r     <= (in_if.param_v > ONE_Q) ? ONE_Q : in_if.param_v;
              tsel_r   <= 2'd0;
              idx_r    <= '0;
              k_r      <= '0;
              wacc_r   <= wgt_init(nu_r, 3'd0);
              state_r  <= ST_BMUL;
            end
          end
        end
        ST_BMUL: begin
          state_r <= ST_BRND;
        end
        ST_BRND: begin
          state_r <= ST_BMUL;
          if (k_r + IDX_W'(1) != tab_n) begin
            wacc_r <= rnd_w;
            k_r    <= k_r + IDX_W'(1);
          end else begin
            wt_r[tsel_r][idx_r] <= rnd_w;
            k_r <= '0;
            if (idx_r == tab_n) begin
              if (tsel_r == 2'd3) begin
                gi_r    <= '0;
                gj_r    <= '0;
                gstep_r <= '0;
                state_r <= ST_GRID;
              end else begin
                tsel_r <= tsel_r + 2'd1;
                idx_r  <= '0;
                wacc_r <= wgt_init(deg_of(tsel_r + 2'd1, nu_r, nv_r), 3'd0);
              end
            end else begin
              idx_r  <= idx_r + IDX_W'(1);
              wacc_r <= wgt_init(tab_n, idx_r + IDX_W'(1));
            end
          end
        end
        ST_GRID: begin
          // neighbor fetch and differences
          case (gstep_r)
            4'd1: for (int c = 0; c < 3; c++) p_r[c] <= rd_c[c];
            4'd2: for (int c = 0; c < 3; c++) dr_r[c] <= DIFF_W'(rd_c[c]) - DIFF_W'(p_r[c]);
            4'd3: for (int c = 0; c < 3; c++) dd_r[c] <= DIFF_W'(rd_c[c]) - DIFF_W'(p_r[c]);
            default: ;
          endcase
          // consume the registered product issued at the previous step
          case (gstep_r)
            4'd1:               w_r  <= rnd_w;
            4'd2:               wu_r <= rnd_w;
            4'd3:               wv_r <= rnd_w;
            4'd4, 4'd5, 4'd6:
              pos_acc_r[2'(gstep_r - 4'd4)] <= pos_acc_r[2'(gstep_r - 4'd4)] + rnd_acc;
            4'd7, 4'd8, 4'd9:
              gu_acc_r[2'(gstep_r - 4'd7)] <= gu_acc_r[2'(gstep_r - 4'd7)] + rnd_acc;
            4'd10, 4'd11, 4'd12:
              gv_acc_r[2'(gstep_r - 4'd10)] <= gv_acc_r[2'(gstep_r - 4'd10)] + rnd_acc;
            default: ;
          endcase
          // next grid point
          if (gstep_r == 4'd12) begin
            gstep_r <= '0;
            if (gj_r == nu_r) begin
              gj_r <= '0;
              if (gi_r == nv_r) begin
                state_r <= ST_FIN;
              end else begin
                gi_r <= gi_r + IDX_W'(1);
              end
            end else begin
              gj_r <= gj_r + IDX_W'(1);
            end
          end else begin
            gstep_r <= gstep_r + 4'd1;
          end
        end
        ST_FIN: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int c = 0; c < 3; c++) begin
        pos_out_r[c] <= sat_pos(pos_acc_r[c]);
        du_out_r[c]  <= sat_der(gu_sc[c]);
        dv_out_r[c]  <= sat_der(gv_sc[c]);
      end
      status_out_r <= status_r;
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.pos_x  = pos_out_r[0];
  assign out_if.pos_y  = pos_out_r[1];
  assign out_if.pos_z  = pos_out_r[2];
  assign out_if.du_x   = du_out_r[0];
  assign out_if.du_y   = du_out_r[1];
  assign out_if.du_z   = du_out_r[2];
  assign out_if.dv_x   = dv_out_r[0];
  assign out_if.dv_y   = dv_out_r[1];
  assign out_if.dv_z   = dv_out_r[2];
  assign out_if.status = status_out_r;

endmodule

// ----- bench/bse_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels and the register port, predicts each result and compares.
module bse_checker import bse_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  bse_in_if.sink                mon_in,
  bse_out_if.sink               mon_out,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic                  cfg_pready,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output int                    fail_count,
  output int                    pending_count
);

  typedef struct {
    logic signed [COORD_W-1:0] pos [3];
    logic signed [DERIV_W-1:0] du [3];
    logic signed [DERIV_W-1:0] dv [3];
    logic                      status;
  } surf_result_t;

  surf_result_t expected_results[$];
  longint       grid[DIM][DIM][3];
  int           nu, nv;

  assign pending_count = expected_results.size();

  function automatic longint round_mul(longint a, longint b);
    return (a * b + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
  endfunction

  function automatic longint bern_weight(int n, int i, longint t);
    longint s, w;
    int     cfac [5][5] = '{'{1, 0, 0, 0, 0}, '{1, 1, 0, 0, 0}, '{1, 2, 1, 0, 0},
                            '{1, 3, 3, 1, 0}, '{1, 4, 6, 4, 1}};
    s = (longint'(1) << FRAC_BITS) - t;
    if (i > n) return 0;
    w = longint'(cfac[n][i]) << FRAC_BITS;
    for (int k = 0; k < n - i; k++) w = round_mul(w, s);
    for (int k = 0; k < i; k++) w = round_mul(w, t);
    return w;
  endfunction

  // weight (unsigned Q.F) times signed value, rounded half up; floor shift is exact here
  function automatic longint weigh(longint w, longint p);
    longint lo, hi;
    lo = p & ((longint'(1) << FRAC_BITS) - 1);
    hi = (p - lo) >>> FRAC_BITS;
    return w * hi + ((w * lo + (1 << (FRAC_BITS - 1))) >>> FRAC_BITS);
  endfunction

  function automatic longint clamp(longint x, int w);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    return (x > hi) ? hi : (x < lo) ? lo : x;
  endfunction

  function automatic surf_result_t eval_surface(longint tu, longint tv);
    surf_result_t r;
    longint bu[DIM], bv[DIM], du[DIM], dv[DIM];
    longint pos[3], gu[3], gv[3];
    longint w, wu, wv, p;
    for (int c = 0; c < 3; c++) begin
      pos[c] = 0; gu[c] = 0; gv[c] = 0;
    end
    if (tu > (1 << FRAC_BITS)) tu = 1 << FRAC_BITS;
    if (tv > (1 << FRAC_BITS)) tv = 1 << FRAC_BITS;
    for (int j = 0; j <= nu; j++) begin
      bu[j] = bern_weight(nu, j, tu);
      du[j] = bern_weight(nu - 1, j, tu);
    end
    for (int i = 0; i <= nv; i++) begin
      bv[i] = bern_weight(nv, i, tv);
      dv[i] = bern_weight(nv - 1, i, tv);
    end
    for (int i = 0; i <= nv; i++) begin
      for (int j = 0; j <= nu; j++) begin
        w  = round_mul(bu[j], bv[i]);
        wu = (j < nu) ? round_mul(du[j], bv[i]) : 0;
        wv = (i < nv) ? round_mul(bu[j], dv[i]) : 0;
        for (int c = 0; c < 3; c++) begin
          p = grid[i][j][c];
          pos[c] += weigh(w, p);
          if (j < nu) gu[c] += weigh(wu, grid[i][j + 1][c] - p);
          if (i < nv) gv[c] += weigh(wv, grid[i + 1][j][c] - p);
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      r.pos[c] = COORD_W'(clamp(pos[c], COORD_W));
      r.du[c]  = DERIV_W'(clamp(gu[c] * nu, DERIV_W));
      r.dv[c]  = DERIV_W'(clamp(gv[c] * nv, DERIV_W));
    end
    r.status = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic clear_grid();
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++)
        for (int c = 0; c < 3; c++) grid[i][j][c] = 0;
  endtask

  always @(posedge clk) begin
    surf_result_t r, e;
    logic [2:0]   val;
    if (!rst_n) begin
      nu = 3;
      nv = 3;
      fail_count = 0;
      clear_grid();
      expected_results.delete();
    end else begin
      // degree register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        val = cfg_pwdata[2:0];
        if (cfg_paddr[CFG_ADDR_W-1:2] <= 1 && cfg_paddr[1:0] == 0 &&
            val >= 2 && val <= MAX_DEGREE) begin
          if (cfg_paddr[2] == REG_U_DEGREE) nu = val; else nv = val;
          clear_grid();
        end
      end
      // accepted request
      if (mon_in.valid && mon_in.ready) begin
        if (mon_in.cmd == CMD_WRITE) begin
          r = '{default: '0};
          for (int c = 0; c < 3; c++) begin
            r.pos[c] = '0; r.du[c] = '0; r.dv[c] = '0;
          end
          if (mon_in.u_index > nu || mon_in.v_index > nv) r.status = 1'b1;
          else begin
            r.status = 1'b0;
            grid[mon_in.v_index][mon_in.u_index][0] = longint'(mon_in.ctrl_x);
            grid[mon_in.v_index][mon_in.u_index][1] = longint'(mon_in.ctrl_y);
            grid[mon_in.v_index][mon_in.u_index][2] = longint'(mon_in.ctrl_z);
          end
        end else begin
          r = eval_surface(longint'(mon_in.param_u), longint'(mon_in.param_v));
        end
        expected_results.push_back(r);
      end
      // delivered result
      if (mon_out.valid && mon_out.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with no request pending", $realtime);
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          if (mon_out.pos_x !== e.pos[0]) report_mismatch("pos_x", mon_out.pos_x, e.pos[0]);
          if (mon_out.pos_y !== e.pos[1]) report_mismatch("pos_y", mon_out.pos_y, e.pos[1]);
          if (mon_out.pos_z !== e.pos[2]) report_mismatch("pos_z", mon_out.pos_z, e.pos[2]);
          if (mon_out.du_x !== e.du[0]) report_mismatch("du_x", mon_out.du_x, e.du[0]);
          if (mon_out.du_y !== e.du[1]) report_mismatch("du_y", mon_out.du_y, e.du[1]);
          if (mon_out.du_z !== e.du[2]) report_mismatch("du_z", mon_out.du_z, e.du[2]);
          if (mon_out.dv_x !== e.dv[0]) report_mismatch("dv_x", mon_out.dv_x, e.dv[0]);
          if (mon_out.dv_y !== e.dv[1]) report_mismatch("dv_y", mon_out.dv_y, e.dv[1]);
          if (mon_out.dv_z !== e.dv[2]) report_mismatch("dv_z", mon_out.dv_z, e.dv[2]);
          if (mon_out.status !== e.status)
            report_mismatch("status", mon_out.status, e.status);
        end
      end
    end
  end

endmodule

// ----- bench/tb_bezier_surface_evaluator_top.sv -----
`timescale 1ns / 1ps

module tb_bezier_surface_evaluator_top;
  import bse_pkg::*;

  localparam longint CYCLE_LIMIT = 3_000_000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;
  int                    fail_count, pending_count;
  longint                cycle_count;
  bit                    sink_quiet;   // no receiver stalls in the last part
  bit                    hold_sink;    // long receiver hold-off request

  bse_in_if  in_if ();
  bse_out_if out_if ();

  bezier_surface_evaluator_top u_top (
    .clk, .rst_n, .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  bse_checker u_checker (
    .clk, .rst_n, .mon_in(in_if.sink), .mon_out(out_if.sink),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_pready, .cfg_paddr, .cfg_pwdata,
    .fail_count, .pending_count
  );

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    int n;
    out_if.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_sink) begin
        out_if.ready <= 1'b0;
        repeat (3000) @(posedge clk);
        hold_sink = 1'b0;
      end else if (!sink_quiet && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        n = $urandom_range(1, 18);
        repeat (n) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic reg_write(int idx, logic [CFG_DATA_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(4 * idx);
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk iff cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays up after acceptance; the next request, a gap or drain() drops or reuses it
  task automatic send_request(logic cmd, logic [2:0] ui, logic [2:0] vi,
                              logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [PARAM_W-1:0] pu, logic [PARAM_W-1:0] pv,
                              bit gaps);
    int n;
    if (gaps && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      n = $urandom_range(1, 18);
      repeat (n) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.cmd     <= cmd;
    in_if.u_index <= ui;
    in_if.v_index <= vi;
    in_if.ctrl_x  <= x;
    in_if.ctrl_y  <= y;
    in_if.ctrl_z  <= z;
    in_if.param_u <= pu;
    in_if.param_v <= pv;
    @(posedge clk iff in_if.ready);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [PARAM_W-1:0] rand_param();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ONE_Q;
      2: return PARAM_W'($urandom_range(ONE_Q + 1, (1 << PARAM_W) - 1));
      default: return PARAM_W'($urandom_range(0, ONE_Q));
    endcase
  endfunction

  // fill the active patch, then evaluate a few points
  task automatic random_patch(int nu, int nv, int evals, bit gaps);
    for (int i = 0; i <= nv; i++)
      for (int j = 0; j <= nu; j++)
        send_request(CMD_WRITE, 3'(j), 3'(i), rand_coord(), rand_coord(), rand_coord(),
                     PARAM_W'($urandom), PARAM_W'($urandom), gaps);
    for (int k = 0; k < evals; k++)
      send_request(CMD_EVAL, 3'($urandom), 3'($urandom), $urandom, $urandom, $urandom,
                   rand_param(), rand_param(), gaps);
  endtask

  initial begin
    int nu, nv, sent;
    rst_n       = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    in_if.valid = 1'b0;
    in_if.cmd   = CMD_WRITE;
    in_if.u_index = '0;
    in_if.v_index = '0;
    in_if.ctrl_x = '0;
    in_if.ctrl_y = '0;
    in_if.ctrl_z = '0;
    in_if.param_u = '0;
    in_if.param_v = '0;
    sink_quiet  = 1'b0;
    hold_sink   = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset degrees, extremes, out-of-range indexes
    send_request(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(CMD_WRITE, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0);
    send_request(CMD_WRITE, 3, 3, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 0, 0, 0);
    send_request(CMD_WRITE, 3, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0);
    send_request(CMD_WRITE, 0, 3, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
    send_request(CMD_WRITE, 4, 0, 1, 1, 1, 0, 0, 0);
    send_request(CMD_WRITE, 0, 4, 1, 1, 1, 0, 0, 0);
    send_request(CMD_WRITE, 7, 7, 1, 1, 1, 0, 0, 0);
    send_request(CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 0);
    send_request(CMD_EVAL, 0, 0, 0, 0, 0, ONE_Q, ONE_Q, 0);
    send_request(CMD_EVAL, 0, 0, 0, 0, 0, 17'h1ffff, 17'h1ffff, 0);
    send_request(CMD_EVAL, 0, 0, 0, 0, 0, 17'h08000, 17'h0ffff, 0);
    drain();

    // illegal degree values are ignored; register index 2 wraps onto the u degree register
    reg_write(0, 1);
    reg_write(1, 5);
    reg_write(0, 32'hffff_fff8);
    reg_write(2, 4);
    send_request(CMD_EVAL, 0, 0, 0, 0, 0, 17'h04000, 17'h0c000, 0);
    drain();

    // extreme degrees
    reg_write(0, 4);
    reg_write(1, 4);
    send_request(CMD_WRITE, 4, 4, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 0, 0, 0);
    send_request(CMD_WRITE, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'hedcb_a988, 0, 0, 0);
    send_request(CMD_EVAL, 0, 0, 0, 0, 0, 17'h08000, 17'h08000, 0);
    drain();
    reg_write(0, 2);
    reg_write(1, 2);
    send_request(CMD_WRITE, 3, 2, 1, 1, 1, 0, 0, 0);
    send_request(CMD_WRITE, 2, 2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0);
    send_request(CMD_EVAL, 0, 0, 0, 0, 0, ONE_Q, ONE_Q, 0);
    drain();

    // long receiver hold-off while requests keep coming
    hold_sink = 1'b1;
    random_patch(2, 2, 6, 0);
    drain();

    // random phases over degree settings; sender pauses until drained between phases
    sent = 0;
    while (sent < 800) begin
      nu = $urandom_range(2, 4);
      nv = $urandom_range(2, 4);
      reg_write(0, nu);
      reg_write(1, nv);
      if (sent > 650) sink_quiet = 1'b1;
      random_patch(nu, nv, 8, !sink_quiet);
      sent += (nu + 1) * (nv + 1) + 8;
      // noise: random writes, some out of range, and evaluations
      for (int k = 0; k < 10; k++) begin
        if ($urandom_range(0, 1))
          send_request(CMD_WRITE, 3'($urandom), 3'($urandom), rand_coord(), rand_coord(),
                       rand_coord(), PARAM_W'($urandom), PARAM_W'($urandom), !sink_quiet);
        else
          send_request(CMD_EVAL, 3'($urandom), 3'($urandom), $urandom, $urandom, $urandom,
                       rand_param(), rand_param(), !sink_quiet);
      end
      sent += 10;
      drain();
    end

    // wait for the tail, then the verdict
    drain();
    repeat (700) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- bezier_surface_evaluator_top.f -----
hdl/bse_pkg.sv
hdl/bse_in_if.sv
hdl/bse_out_if.sv
hdl/bse_mul.sv
hdl/bse_store.sv
hdl/bezier_surface_evaluator_top.sv
bench/bse_checker.sv
bench/tb_bezier_surface_evaluator_top.sv
